@@ sv/mfp_pkg.sv @@
// Shared types, constants and helper functions for the Mollweide forward projection.
// Used by every module of the block; depends on nothing else.
package mfp_pkg;

   // Iteration counts.
   localparam int NEWTON_STEPS = 8;
   localparam int CORDIC_STEPS = 28;

   // Port field widths.
   localparam int LAT_W = 24;
   localparam int LON_W = 25;
   localparam int X_W   = 27;
   localparam int Y_W   = 26;

   // Internal widths.
   localparam int ANG_W      = 36;
   localparam int MAG_W      = 34;
   localparam int PROD_W     = 2 * MAG_W;
   localparam int DIV_NUM_W  = 64;
   localparam int DIV_DEN_W  = 36;
   localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
   localparam int COR_IDX_W  = $clog2(CORDIC_STEPS);
   localparam int ITER_W     = $clog2(NEWTON_STEPS + 1);

   // Fixed-point scaling.
   localparam int FRAC   = 30;
   localparam int OUT_SH = 36;
   localparam int X_MAX  = (1 << (X_W - 1)) - 1;
   localparam int Y_MAX  = (1 << (Y_W - 1)) - 1;

   // Degrees to radians: divide by 180 * 2^16 = 45 * 2^18, rounded.
   localparam int DEG_SHIFT = 18;
   localparam int DEG_DIV   = 45;
   localparam int DEG_HALF  = 5898240;

   // Divide by 45 one byte of quotient per cycle. Each byte comes from a
   // reciprocal multiplication that is exact for partial values below 45 * 256.
   localparam int DEG_NUM_W    = 40;
   localparam int DEG_DIGIT_W  = 8;
   localparam int DEG_DIGITS   = DEG_NUM_W / DEG_DIGIT_W;
   localparam int DEG_CNT_W    = $clog2(DEG_DIGITS);
   localparam int DEG_REM_W    = $clog2(DEG_DIV);
   localparam int DEG_PART_W   = DEG_REM_W + DEG_DIGIT_W;
   localparam int DEG_RECIP_W  = 15;
   localparam int DEG_PROD_W   = DEG_PART_W + DEG_RECIP_W;
   localparam int DEG_RECIP    = 23302;
   localparam int DEG_RECIP_SH = 20;

   typedef logic signed [ANG_W-1:0] ang_type;

   // Q30 constants.
   localparam ang_type PI_Q      = 36'sh0C90FDAA2;
   localparam ang_type HALF_PI_Q = PI_Q >>> 1;
   localparam ang_type TWO_PI_Q  = PI_Q <<< 1;
   localparam ang_type SQRT2_Q   = 36'sh05A82799A;
   localparam ang_type GAIN_Q    = 36'sh026DD3B6A;
   localparam ang_type ONE_Q     = 36'sh040000000;
   localparam ang_type DF_MIN    = 36'sd64;
   localparam logic [63:0] SCALE_X_RAW =
      ((64'h0B504F334 << FRAC) + 64'h0C90FDAA2 / 2) / 64'h0C90FDAA2;
   localparam ang_type SCALE_X_Q = ANG_W'(SCALE_X_RAW);

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_LAT,
      OP_MUL_LON,
      OP_DIV_DEG,
      OP_SET_PHI,
      OP_SET_LAM,
      OP_COR_PHI,
      OP_MUL_TGT,
      OP_SET_TGT,
      OP_COR_2TH,
      OP_EVAL,
      OP_DIV_F,
      OP_UPD,
      OP_COR_TH,
      OP_MUL_LC,
      OP_SET_TMP,
      OP_MUL_SX,
      OP_SET_X,
      OP_MUL_Y,
      OP_SET_Y,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic cor_done;
      logic div_done;
      logic deg_done;
      logic df_small;
      logic conv;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_LAT,
      ST_DIV_LAT,
      ST_WAIT_LAT,
      ST_MUL_LON,
      ST_DIV_LON,
      ST_WAIT_LON,
      ST_COR_PHI,
      ST_WAIT_PHI,
      ST_SET_TGT,
      ST_COR_2TH,
      ST_WAIT_2TH,
      ST_CHECK,
      ST_WAIT_F,
      ST_COR_TH,
      ST_WAIT_TH,
      ST_SET_TMP,
      ST_MUL_SX,
      ST_SET_X,
      ST_MUL_Y,
      ST_SET_Y,
      ST_OUT
   } ctrl_state_type;

   // CORDIC arctangent of 2^-idx in Q30.
   function automatic ang_type atan_q(input logic [COR_IDX_W-1:0] idx);
      ang_type r;
      case (int'(idx))
         0: r = 36'sh03243F6A8;
         1: r = 36'sh01DAC6705;
         2: r = 36'sh00FADBAFC;
         3: r = 36'sh007F56EA6;
         4: r = 36'sh003FEAB76;
         5: r = 36'sh001FFD55B;
         6: r = 36'sh000FFFAAA;
         7: r = 36'sh0007FFF55;
         8: r = 36'sh0003FFFEA;
         9: r = 36'sh0001FFFFD;
         default: begin
            if (int'(idx) <= FRAC) begin
               r = ang_type'(36'sd1 <<< (FRAC - int'(idx)));
            end else begin
               r = '0;
            end
         end
      endcase
      return r;
   endfunction

endpackage

@@ sv/mfp_cordic.sv @@
// Iterative rotation-mode CORDIC giving sine and cosine in Q30, one micro-rotation per cycle.
// Depends on mfp_pkg.
module mfp_cordic (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  mfp_pkg::ang_type angle,
   output logic            done,
   output mfp_pkg::ang_type sin_out,
   output mfp_pkg::ang_type cos_out
);
   import mfp_pkg::*;

   ang_type x_ff, y_ff, z_ff;
   logic    neg_ff;
   logic [COR_IDX_W-1:0] idx_ff;
   logic    busy_ff, done_ff;

   ang_type a_wrap, a_fold;
   logic    fold_neg;
   ang_type dx, dy, at;

   // Wrap the angle to [-pi, pi] and fold it into [-pi/2, pi/2].
   always_comb begin
      if (angle > PI_Q) begin
         a_wrap = angle - TWO_PI_Q;
      end else if (angle < -PI_Q) begin
         a_wrap = angle + TWO_PI_Q;
      end else begin
         a_wrap = angle;
      end
      fold_neg = 1'b0;
      a_fold   = a_wrap;
      if (a_wrap > HALF_PI_Q) begin
         a_fold   = PI_Q - a_wrap;
         fold_neg = 1'b1;
      end else if (a_wrap < -HALF_PI_Q) begin
         a_fold   = -PI_Q - a_wrap;
         fold_neg = 1'b1;
      end
   end

   // Shifted terms for the current micro-rotation.
   assign dx = y_ff >>> idx_ff;
   assign dy = x_ff >>> idx_ff;
   assign at = atan_q(idx_ff);

   // Iteration control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff) begin
            if (idx_ff == COR_IDX_W'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // Vector and residual angle.
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= GAIN_Q;
         y_ff   <= '0;
         z_ff   <= a_fold;
         neg_ff <= fold_neg;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end
      end
   end

   assign done    = done_ff;
   assign sin_out = y_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;

endmodule

@@ sv/mfp_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mfp_pkg.
module mfp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [mfp_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [mfp_pkg::DIV_DEN_W-1:0] divisor,
   output logic                 done,
   output logic [mfp_pkg::DIV_NUM_W-1:0] quotient
);
   import mfp_pkg::*;

   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_DEN_W-1:0] den_ff, rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;

   logic [DIV_DEN_W:0]   rem_sh, den_ext, rem_sub;
   logic                 ge;

   // One trial subtraction.
   always_comb begin
      rem_sh  = {rem_ff, num_ff[DIV_NUM_W-1]};
      den_ext = {1'b0, den_ff};
      ge      = (rem_sh >= den_ext);
      rem_sub = rem_sh - den_ext;
   end

   // Iteration control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // Partial remainder and quotient shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         num_ff <= {num_ff[DIV_NUM_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

@@ sv/mfp_dp.sv @@
// Datapath of the projection: operand registers, multiplier, rounding, Newton update.
// Depends on mfp_pkg, mfp_cordic and mfp_div.
module mfp_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  mfp_pkg::dp_cmd_type         cmd,
   input  logic signed [mfp_pkg::LAT_W-1:0] req_latitude,
   input  logic signed [mfp_pkg::LON_W-1:0] req_longitude,
   output mfp_pkg::dp_status_type      status,
   output logic signed [mfp_pkg::X_W-1:0]   rsp_map_x,
   output logic signed [mfp_pkg::Y_W-1:0]   rsp_map_y
);
   import mfp_pkg::*;

   logic signed [LAT_W-1:0] lat_ff;
   logic signed [LON_W-1:0] lon_ff;
   ang_type phi_ff, lam_ff, target_ff, theta_ff, f_ff, df_ff, tmp_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              pneg_ff;
   logic signed [X_W-1:0] x_ff, rsp_x_ff;
   logic signed [Y_W-1:0] y_ff, rsp_y_ff;

   // Unit interfaces.
   logic    cor_start, cor_done;
   ang_type cor_angle, cor_sin, cor_cos;
   logic    div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_quot;
   logic [DIV_DEN_W-1:0] div_den;

   // Degree conversion divider.
   logic                  deg_start;
   logic [DEG_NUM_W-1:0]  deg_num_ff;
   logic [DEG_REM_W-1:0]  deg_rem_ff;
   logic [DEG_CNT_W-1:0]  deg_cnt_ff;
   logic                  deg_busy_ff, deg_done_ff;
   logic [DEG_PART_W-1:0] deg_part, deg_rem_part;
   logic [DEG_PROD_W-1:0] deg_prod;
   logic [DEG_DIGIT_W-1:0] deg_digit;

   // Multiplier operands.
   ang_type mul_a, mul_b;
   logic [MAG_W-1:0] mag_a, mag_b;
   logic [PROD_W-1:0] prod_in;
   logic mul_en;

   // Rounded products.
   logic [PROD_W-1:0] r30_full, r36;
   ang_type r30, r30_s;
   logic [X_W-1:0] x_mag;
   logic [Y_W-1:0] y_mag;
   logic signed [X_W-1:0] x_val;
   logic signed [Y_W-1:0] y_val;

   // Newton terms.
   ang_type f_in, df_in, f_mag, qd, phi_clamp;
   logic signed [DIV_NUM_W+1:0] theta_w, q_w, nxt_w;
   ang_type next_th;
   logic signed [ANG_W:0] th_diff;

   mfp_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .sin_out (cor_sin),
      .cos_out (cor_cos)
   );

   mfp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Operand selection for the multiplier, CORDIC and dividers.
   always_comb begin
      mul_en    = 1'b1;
      mul_a     = PI_Q;
      mul_b     = PI_Q;
      cor_start = 1'b0;
      cor_angle = phi_ff;
      div_start = 1'b0;
      deg_start = 1'b0;
      div_num   = DIV_NUM_W'(f_mag) << FRAC;
      div_den   = DIV_DEN_W'(df_ff);
      case (cmd.op)
         OP_MUL_LAT: mul_a = ANG_W'(lat_ff);
         OP_MUL_LON: mul_a = ANG_W'(lon_ff);
         OP_MUL_TGT: mul_b = cor_sin;
         OP_MUL_LC: begin
            mul_a = lam_ff;
            mul_b = cor_cos;
         end
         OP_MUL_SX: begin
            mul_a = SCALE_X_Q;
            mul_b = tmp_ff;
         end
         OP_MUL_Y: begin
            mul_a = SQRT2_Q;
            mul_b = cor_sin;
         end
         OP_DIV_DEG: begin
            mul_en    = 1'b0;
            deg_start = 1'b1;
         end
         OP_DIV_F: begin
            mul_en    = 1'b0;
            div_start = 1'b1;
         end
         OP_COR_PHI: begin
            mul_en    = 1'b0;
            cor_start = 1'b1;
         end
         OP_COR_2TH: begin
            mul_en    = 1'b0;
            cor_start = 1'b1;
            cor_angle = theta_ff <<< 1;
         end
         OP_COR_TH: begin
            mul_en    = 1'b0;
            cor_start = 1'b1;
            cor_angle = theta_ff;
         end
         default: mul_en = 1'b0;
      endcase
      mag_a   = MAG_W'((mul_a < 0) ? -mul_a : mul_a);
      mag_b   = MAG_W'((mul_b < 0) ? -mul_b : mul_b);
      prod_in = PROD_W'(mag_a) * PROD_W'(mag_b);
   end

   // One quotient byte of the divide by 45: reciprocal estimate and remainder.
   always_comb begin
      deg_part     = {deg_rem_ff, deg_num_ff[DEG_NUM_W-1 -: DEG_DIGIT_W]};
      deg_prod     = DEG_PROD_W'(deg_part) * DEG_PROD_W'(DEG_RECIP);
      deg_digit    = DEG_DIGIT_W'(deg_prod >> DEG_RECIP_SH);
      deg_rem_part = deg_part - DEG_PART_W'(deg_digit) * DEG_PART_W'(DEG_DIV);
   end

   // Divide-by-45 iteration control.
   always_ff @(posedge clock) begin
      if (reset) begin
         deg_busy_ff <= 1'b0;
         deg_done_ff <= 1'b0;
         deg_cnt_ff  <= '0;
      end else begin
         deg_done_ff <= 1'b0;
         if (deg_start) begin
            deg_busy_ff <= 1'b1;
            deg_cnt_ff  <= '0;
         end else if (deg_busy_ff) begin
            if (deg_cnt_ff == DEG_CNT_W'(DEG_DIGITS - 1)) begin
               deg_busy_ff <= 1'b0;
               deg_done_ff <= 1'b1;
            end
            deg_cnt_ff <= deg_cnt_ff + 1'b1;
         end
      end
   end

   // Rounded dividend in, quotient bytes shifted in behind it.
   always_ff @(posedge clock) begin
      if (deg_start) begin
         deg_num_ff <= DEG_NUM_W'((prod_ff + PROD_W'(DEG_HALF)) >> DEG_SHIFT);
         deg_rem_ff <= '0;
      end else if (deg_busy_ff) begin
         deg_num_ff <= {deg_num_ff[DEG_NUM_W-DEG_DIGIT_W-1:0], deg_digit};
         deg_rem_ff <= DEG_REM_W'(deg_rem_part);
      end
   end

   // Rounding of the registered product, half away from zero, with saturation.
   always_comb begin
      r30_full = (prod_ff + (PROD_W'(1) << (FRAC - 1))) >> FRAC;
      r30      = ANG_W'(r30_full);
      r30_s    = pneg_ff ? -r30 : r30;
      r36      = (prod_ff + (PROD_W'(1) << (OUT_SH - 1))) >> OUT_SH;
      x_mag    = X_W'(r36);
      y_mag    = Y_W'(r36);
      if (!pneg_ff) begin
         x_val = (r36 > PROD_W'(X_MAX)) ? X_W'(X_MAX) : x_mag;
         y_val = (r36 > PROD_W'(Y_MAX)) ? Y_W'(Y_MAX) : y_mag;
      end else begin
         x_val = (r36 > PROD_W'(X_MAX + 1)) ? X_W'(-X_MAX - 1) : -x_mag;
         y_val = (r36 > PROD_W'(Y_MAX + 1)) ? Y_W'(-Y_MAX - 1) : -y_mag;
      end
   end

   // Newton residual, derivative and update.
   always_comb begin
      f_in    = (theta_ff <<< 1) + cor_sin - target_ff;
      df_in   = (ONE_Q <<< 1) + (cor_cos <<< 1);
      f_mag   = (f_ff < 0) ? -f_ff : f_ff;
      qd      = ANG_W'(deg_num_ff);
      theta_w = (DIV_NUM_W + 2)'(theta_ff);
      q_w     = {2'b00, div_quot};
      nxt_w   = (f_ff < 0) ? theta_w + q_w : theta_w - q_w;
      if (nxt_w > (DIV_NUM_W + 2)'(HALF_PI_Q)) begin
         next_th = HALF_PI_Q;
      end else if (nxt_w < (DIV_NUM_W + 2)'(-HALF_PI_Q)) begin
         next_th = -HALF_PI_Q;
      end else begin
         next_th = ANG_W'(nxt_w);
      end
      th_diff = (ANG_W + 1)'(next_th) - (ANG_W + 1)'(theta_ff);
      if (phi_ff > HALF_PI_Q) begin
         phi_clamp = HALF_PI_Q;
      end else if (phi_ff < -HALF_PI_Q) begin
         phi_clamp = -HALF_PI_Q;
      end else begin
         phi_clamp = phi_ff;
      end
   end

   // Multiplier output register.
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
         pneg_ff <= (mul_a < 0) != (mul_b < 0);
      end
   end

   // Operand and result registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            lat_ff <= req_latitude;
            lon_ff <= req_longitude;
         end
         OP_SET_PHI: phi_ff <= pneg_ff ? -qd : qd;
         OP_SET_LAM: lam_ff <= pneg_ff ? -qd : qd;
         OP_SET_TGT: begin
            target_ff <= r30_s;
            theta_ff  <= phi_clamp;
         end
         OP_EVAL: begin
            f_ff  <= f_in;
            df_ff <= df_in;
         end
         OP_UPD:     theta_ff <= next_th;
         OP_SET_TMP: tmp_ff <= r30_s;
         OP_SET_X:   x_ff <= x_val;
         OP_SET_Y:   y_ff <= y_val;
         OP_OUT: begin
            rsp_x_ff <= x_ff;
            rsp_y_ff <= y_ff;
         end
         default: begin
         end
      endcase
   end

   assign status.cor_done = cor_done;
   assign status.div_done = div_done;
   assign status.deg_done = deg_done_ff;
   assign status.df_small = (df_ff <= DF_MIN);
   assign status.conv     = (th_diff == 0) || (th_diff == 1) || (th_diff == -1);

   assign rsp_map_x = rsp_x_ff;
   assign rsp_map_y = rsp_y_ff;

endmodule

@@ sv/mfp_ctrl.sv @@
// Controller state machine that sequences the projection datapath and the handshakes.
// Depends on mfp_pkg.
module mfp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mfp_pkg::dp_status_type status,
   output mfp_pkg::dp_cmd_type    cmd
);
   import mfp_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic rsp_valid_ff, rsp_valid_in;

   // State, iteration count and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_MUL_LAT;
            end
         end
         ST_MUL_LAT: begin
            cmd.op   = OP_MUL_LAT;
            state_in = ST_DIV_LAT;
         end
         ST_DIV_LAT: begin
            cmd.op   = OP_DIV_DEG;
            state_in = ST_WAIT_LAT;
         end
         ST_WAIT_LAT: begin
            if (status.deg_done) begin
               cmd.op   = OP_SET_PHI;
               state_in = ST_MUL_LON;
            end
         end
         ST_MUL_LON: begin
            cmd.op   = OP_MUL_LON;
            state_in = ST_DIV_LON;
         end
         ST_DIV_LON: begin
            cmd.op   = OP_DIV_DEG;
            state_in = ST_WAIT_LON;
         end
         ST_WAIT_LON: begin
            if (status.deg_done) begin
               cmd.op   = OP_SET_LAM;
               state_in = ST_COR_PHI;
            end
         end
         ST_COR_PHI: begin
            cmd.op   = OP_COR_PHI;
            state_in = ST_WAIT_PHI;
         end
         ST_WAIT_PHI: begin
            if (status.cor_done) begin
               cmd.op   = OP_MUL_TGT;
               state_in = ST_SET_TGT;
            end
         end
         ST_SET_TGT: begin
            cmd.op   = OP_SET_TGT;
            iter_in  = '0;
            state_in = ST_COR_2TH;
         end
         ST_COR_2TH: begin
            cmd.op   = OP_COR_2TH;
            state_in = ST_WAIT_2TH;
         end
         ST_WAIT_2TH: begin
            if (status.cor_done) begin
               cmd.op   = OP_EVAL;
               state_in = ST_CHECK;
            end
         end
         // A flat derivative ends the iteration, as at the poles.
         ST_CHECK: begin
            if (status.df_small) begin
               state_in = ST_COR_TH;
            end else begin
               cmd.op   = OP_DIV_F;
               state_in = ST_WAIT_F;
            end
         end
         ST_WAIT_F: begin
            if (status.div_done) begin
               cmd.op = OP_UPD;
               if (status.conv || (iter_ff == ITER_W'(NEWTON_STEPS - 1))) begin
                  state_in = ST_COR_TH;
               end else begin
                  iter_in  = iter_ff + 1'b1;
                  state_in = ST_COR_2TH;
               end
            end
         end
         ST_COR_TH: begin
            cmd.op   = OP_COR_TH;
            state_in = ST_WAIT_TH;
         end
         ST_WAIT_TH: begin
            if (status.cor_done) begin
               cmd.op   = OP_MUL_LC;
               state_in = ST_SET_TMP;
            end
         end
         ST_SET_TMP: begin
            cmd.op   = OP_SET_TMP;
            state_in = ST_MUL_SX;
         end
         ST_MUL_SX: begin
            cmd.op   = OP_MUL_SX;
            state_in = ST_SET_X;
         end
         ST_SET_X: begin
            cmd.op   = OP_SET_X;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.op   = OP_MUL_Y;
            state_in = ST_SET_Y;
         end
         ST_SET_Y: begin
            cmd.op   = OP_SET_Y;
            state_in = ST_OUT;
         end
         // Move the result into the output register once it is free.
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/mollweide_forward_projection.sv @@
// Top level of the Mollweide forward projection.
// Depends on mfp_pkg, mfp_ctrl and mfp_dp.
//
// Usage:
//   The req channel carries one point per transaction: latitude and longitude
//   in degrees, signed with 16 fraction bits. The rsp channel returns map_x
//   and map_y, signed with 24 fraction bits. Both channels use valid/ready.
//   The two degree conversions are each a multiply and a divide by 45 that
//   yields one quotient byte per cycle. A full Newton step is one CORDIC
//   pass, a check state and a bit-serial division of a 64-bit dividend; a
//   step that finds a flat derivative ends after the check. The step count
//   drops when the iteration converges or the derivative vanishes.
//   One point is handled at a time: no new request is taken until the
//   result of the last one is in the output register.
//   A finished result sits in an output register, so the next request is
//   taken while rsp_ready is low; the controller only waits when a second
//   result is done before the first one is taken.
//   Reset is synchronous and active high; it returns the controller to idle
//   and drops rsp_valid.
module mollweide_forward_projection (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [mfp_pkg::LAT_W-1:0] req_latitude,
   input  logic signed [mfp_pkg::LON_W-1:0] req_longitude,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [mfp_pkg::X_W-1:0]   rsp_map_x,
   output logic signed [mfp_pkg::Y_W-1:0]   rsp_map_y
);
   import mfp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   mfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic.
   mfp_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_latitude  (req_latitude),
      .req_longitude (req_longitude),
      .status        (status),
      .rsp_map_x     (rsp_map_x),
      .rsp_map_y     (rsp_map_y)
   );

endmodule

@@ bench/mollweide_forward_projection_tb.sv @@
// Self-checking testbench for the Mollweide forward projection block.
// Depends on mfp_pkg for port widths and on mollweide_forward_projection.
// A bit-exact fixed-point model predicts each point; a scoreboard checks results in order.
`timescale 1ns / 100ps

module mollweide_forward_projection_tb;
   import mfp_pkg::*;

   localparam longint PI_FX    = 64'h0C90FDAA2;
   localparam longint HPI_FX   = PI_FX / 2;
   localparam longint TPI_FX   = PI_FX * 2;
   localparam longint ROOT2_FX = 64'h05A82799A;
   localparam longint KGAIN_FX = 64'h026DD3B6A;
   localparam longint UNIT_FX  = 64'h040000000;
   localparam longint DERIV_LO = 64;
   localparam longint XLIM     = (64'sd1 <<< (X_W - 1)) - 1;
   localparam longint YLIM     = (64'sd1 <<< (Y_W - 1)) - 1;
   localparam int     RANDOM_POINTS = 1330;
   localparam int     HOLD_CYCLES   = 4000;
   localparam longint CYCLE_LIMIT   = 8000000;

   typedef struct {
      logic signed [LAT_W-1:0] lat;
      logic signed [LON_W-1:0] lon;
   } geo_point_type;

   typedef struct {
      logic signed [X_W-1:0] x;
      logic signed [Y_W-1:0] y;
   } map_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [LAT_W-1:0] req_latitude = '0;
   logic signed [LON_W-1:0] req_longitude = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [X_W-1:0] rsp_map_x;
   logic signed [Y_W-1:0] rsp_map_y;

   geo_point_type pending_points[$];
   map_point_type expected_points[$];
   logic   req_taken = 1'b0;
   int     send_gap = 0;
   int     take_gap = 0;
   int     hold_left = 0;
   bit     hold_done = 1'b0;
   int     points_sent = 0;
   int     points_checked = 0;
   int     mismatches = 0;
   longint cycles = 0;

   mollweide_forward_projection dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_latitude(req_latitude), .req_longitude(req_longitude),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_map_x(rsp_map_x), .rsp_map_y(rsp_map_y)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Fixed-point arithmetic helpers of the projection.
   function automatic logic [63:0] magnitude(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint mul_round(input longint a, input longint b, input int sh);
      logic [63:0] p, r;
      p = magnitude(a) * magnitude(b);
      r = (p + (64'd1 << (sh - 1))) >> sh;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint limit(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint arctan_step(input int i);
      case (i)
         0: return 64'h03243F6A8;
         1: return 64'h01DAC6705;
         2: return 64'h00FADBAFC;
         3: return 64'h007F56EA6;
         4: return 64'h003FEAB76;
         5: return 64'h001FFD55B;
         6: return 64'h000FFFAAA;
         7: return 64'h0007FFF55;
         8: return 64'h0003FFFEA;
         9: return 64'h0001FFFFD;
         default: return (i <= 30) ? (64'sd1 <<< (30 - i)) : 64'sd0;
      endcase
   endfunction

   // Rotation-mode CORDIC after reduction of the angle to [-pi/2, pi/2].
   function automatic void sin_cos(input longint ang, output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit flip;
      x = KGAIN_FX;
      y = 0;
      flip = 1'b0;
      ang = ang % TPI_FX;
      if (ang > PI_FX) ang -= TPI_FX;
      if (ang < -PI_FX) ang += TPI_FX;
      if (ang > HPI_FX) begin
         ang = PI_FX - ang;
         flip = 1'b1;
      end else if (ang < -HPI_FX) begin
         ang = -PI_FX - ang;
         flip = 1'b1;
      end
      z = ang;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_step(i);
         end else begin
            x += dx; y -= dy; z += arctan_step(i);
         end
      end
      s = y;
      c = flip ? -x : x;
   endfunction

   function automatic longint degrees_to_radians(input longint d);
      logic [63:0] den, q;
      den = 64'd180 << 16;
      q = (magnitude(d) * 64'(PI_FX) + den / 2) / den;
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   // Full forward projection: Newton solve for the auxiliary angle, then x and y.
   function automatic map_point_type project_point(input geo_point_type g);
      map_point_type m;
      longint phi, lam, sp, cp, st, ct, goal, theta, s2, c2, f, df, stp, nxt, xv, yv;
      logic [63:0] q;
      phi = degrees_to_radians(longint'(g.lat));
      lam = degrees_to_radians(longint'(g.lon));
      sin_cos(phi, sp, cp);
      goal = mul_round(PI_FX, sp, 30);
      theta = limit(phi, -HPI_FX, HPI_FX);
      for (int n = 0; n < NEWTON_STEPS; n++) begin
         sin_cos(2 * theta, s2, c2);
         f = 2 * theta + s2 - goal;
         df = 2 * UNIT_FX + 2 * c2;
         if (df <= DERIV_LO) break;
         q = (magnitude(f) << 30) / 64'(df);
         stp = f < 0 ? -longint'(q) : longint'(q);
         nxt = limit(theta - stp, -HPI_FX, HPI_FX);
         if (magnitude(nxt - theta) <= 1) begin
            theta = nxt;
            break;
         end
         theta = nxt;
      end
      sin_cos(theta, st, ct);
      xv = mul_round(longint'(SCALE_X_RAW), mul_round(lam, ct, 30), 36);
      yv = mul_round(ROOT2_FX, st, 36);
      m.x = X_W'(limit(xv, -XLIM - 1, XLIM));
      m.y = Y_W'(limit(yv, -YLIM - 1, YLIM));
      return m;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 11) return 0;
      if (r < 18) return $urandom_range(1, 5);
      return $urandom_range(20, 400);
   endfunction

   function automatic geo_point_type make_point(input longint lat_deg_fx,
                                                input longint lon_deg_fx);
      geo_point_type g;
      g.lat = LAT_W'(lat_deg_fx);
      g.lon = LON_W'(lon_deg_fx);
      return g;
   endfunction

   // Driver: offer the next pending point, holding it until the transaction completes.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_points.size() > 0) begin
         geo_point_type g;
         g = pending_points.pop_front();
         req_latitude <= g.lat;
         req_longitude <= g.lon;
         req_valid <= 1'b1;
         send_gap <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver readiness: random stalls plus one long hold-off to back the block up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && points_checked == 150) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (take_gap > 0) begin
         rsp_ready <= 1'b0;
         take_gap <= take_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) take_gap <= pick_gap();
      end
   end

   // Monitor: predict accepted points and score returned results.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         geo_point_type g;
         g.lat = req_latitude;
         g.lon = req_longitude;
         expected_points.push_back(project_point(g));
         points_sent <= points_sent + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         map_point_type e;
         if (expected_points.size() == 0) begin
            $error("unexpected result transaction: map_x %0d map_y %0d", rsp_map_x, rsp_map_y);
            mismatches = mismatches + 1;
         end else begin
            e = expected_points.pop_front();
            if (rsp_map_x !== e.x) begin
               $error("map_x expected %0d actual %0d", e.x, rsp_map_x);
               mismatches = mismatches + 1;
            end
            if (rsp_map_y !== e.y) begin
               $error("map_y expected %0d actual %0d", e.y, rsp_map_y);
               mismatches = mismatches + 1;
            end
         end
         points_checked <= points_checked + 1;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      longint d;
      int r;
      // Directed points: zero, poles, extremes of both fields, saturation of x.
      pending_points.push_back(make_point(0, 0));
      pending_points.push_back(make_point(90 <<< 16, 180 <<< 16));
      pending_points.push_back(make_point(-(90 <<< 16), -(180 <<< 16)));
      pending_points.push_back(make_point(90 <<< 16, -(180 <<< 16)));
      pending_points.push_back(make_point(-(90 <<< 16), 180 <<< 16));
      pending_points.push_back(make_point((90 <<< 16) - 1, (180 <<< 16) - 1));
      pending_points.push_back(make_point(-(90 <<< 16) + 1, 1));
      pending_points.push_back(make_point(0, 180 <<< 16));
      pending_points.push_back(make_point(0, -(180 <<< 16)));
      pending_points.push_back(make_point(0, 24'hFFFFFF));
      pending_points.push_back(make_point(0, -(64'sd1 <<< 24)));
      pending_points.push_back(make_point(24'h7FFFFF, 24'hFFFFFF));
      pending_points.push_back(make_point(-(64'sd1 <<< 23), -(64'sd1 <<< 24)));
      pending_points.push_back(make_point(100 <<< 16, 90 <<< 16));
      pending_points.push_back(make_point(-(120 <<< 16), -(45 <<< 16)));
      pending_points.push_back(make_point(45 <<< 16, 90 <<< 16));
      pending_points.push_back(make_point(-(45 <<< 16), 30 <<< 16));
      pending_points.push_back(make_point(1, -1));
      pending_points.push_back(make_point(-1, 1));
      pending_points.push_back(make_point(89 <<< 16, 179 <<< 16));
      // Random points: mostly the nominal sphere, some anywhere in the field widths.
      for (int i = 0; i < RANDOM_POINTS; i++) begin
         r = $urandom_range(0, 9);
         if (r < 7) begin
            pending_points.push_back(make_point(
               longint'($urandom_range(0, 2 * 5898240)) - 5898240,
               longint'($urandom_range(0, 2 * 11796480)) - 11796480));
         end else if (r < 8) begin
            // Close to a pole, where the derivative vanishes.
            d = longint'($urandom_range(0, 4096));
            pending_points.push_back(make_point(
               ($urandom_range(0, 1) ? 5898240 - d : d - 5898240),
               longint'($urandom_range(0, 2 * 11796480)) - 11796480));
         end else begin
            pending_points.push_back(make_point(longint'($urandom), longint'($urandom)));
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_points.size() > 0 || req_valid) @(posedge clock);
      while (expected_points.size() > 0) @(posedge clock);
      repeat (1200) @(posedge clock);

      $display("Projected %0d points (directed poles, field extremes, x saturation, random);",
               points_sent);
      $display("checked %0d results under random stalls and one long output hold-off.",
               points_checked);
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ mollweide_forward_projection.f @@
sv/mfp_pkg.sv
sv/mfp_cordic.sv
sv/mfp_div.sv
sv/mfp_dp.sv
sv/mfp_ctrl.sv
sv/mollweide_forward_projection.sv
bench/mollweide_forward_projection_tb.sv
